[design/ibe_pkg.sv]
package ibe_pkg;

  // Fixed field widths
  localparam int unsigned CFG_W     = 9;   // config register payload
  localparam int unsigned CFG_IDX_W = 3;   // config register index
  localparam int unsigned CRD_W     = 10;  // column / row coordinate
  localparam int unsigned PIX_W     = 32;  // packed pixel on the stream
  localparam int unsigned SGN_W     = 12;  // signed offset from the leading pad
  localparam int unsigned MAG_W     = 10;  // magnitude fed to the remainder unit
  localparam int unsigned CNT_W     = $clog2(MAG_W);
  localparam int unsigned NUM_AXES  = 2;   // 0 column, 1 row

  // Stream packing
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 1;
  localparam int unsigned COL_LSB   = 0;
  localparam int unsigned ROW_LSB   = COL_LSB + CRD_W;
  localparam int unsigned PIX_LSB   = ROW_LSB + CRD_W;

  // Defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_PAD    = 256;
  localparam int DEF_CHANNELS   = 4;

  // Register reset values
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic {
    EDGE_REPLICATE = 1'b0,
    EDGE_MIRROR    = 1'b1
  } edge_mode_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_OUTSIDE = 1'b1
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_PAD_LEFT   = 3'd2,
    REG_PAD_RIGHT  = 3'd3,
    REG_PAD_TOP    = 3'd4,
    REG_PAD_BOTTOM = 3'd5,
    REG_EDGE_MODE  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_READ,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // store a load transaction
    logic cap;       // capture fetch coordinates
    logic check;     // bounds check and offsets
    logic prep;      // per-axis mapping setup
    logic div_step;  // one remainder bit per axis
    logic fix;       // final source indexes
    logic rd_en;     // read the store
    logic out_load;  // fill the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic outside;     // fetch coordinate outside the expanded image
    logic div_needed;  // some axis needs the wrap remainder
    logic out_free;    // output register can take a result
  } ctrl_status_t;

endpackage

[design/ibe_ctrl.sv]
module ibe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  ibe_pkg::op_e         s_op_i,
  output logic                 s_tready_o,
  input  ibe_pkg::ctrl_status_t status_i,
  output ibe_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [ibe_pkg::CNT_W-1:0] CNT_LAST = ibe_pkg::CNT_W'(ibe_pkg::MAG_W - 1);

  ibe_pkg::state_e state_q, state_d;
  logic [ibe_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibe_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = '0;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ibe_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (s_op_i == ibe_pkg::OP_FETCH) begin
            cmd_o.cap = 1'b1;
            state_d   = ibe_pkg::ST_CHECK;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ibe_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ibe_pkg::ST_PREP;
      end
      ibe_pkg::ST_PREP: begin
        if (status_i.outside) begin
          state_d = ibe_pkg::ST_DONE;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = ibe_pkg::ST_DIV;
        end
      end
      ibe_pkg::ST_DIV: begin
        if (!status_i.div_needed) begin
          state_d = ibe_pkg::ST_FIX;
        end else begin
          cmd_o.div_step = 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_d = ibe_pkg::ST_FIX;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ibe_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ibe_pkg::ST_READ;
      end
      ibe_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ibe_pkg::ST_DONE;
      end
      ibe_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ibe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ibe_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A fetch starts the mapping sequence
  a_fetch_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_op_i == ibe_pkg::OP_FETCH) |=>
      state_q == ibe_pkg::ST_CHECK)
    else $error("fetch transaction did not start the check step");

  // A load is finished in the cycle it is taken
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_op_i == ibe_pkg::OP_LOAD) |=>
      state_q == ibe_pkg::ST_IDLE)
    else $error("load transaction left the idle state");

  // The remainder unit runs exactly one step per magnitude bit
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibe_pkg::ST_DIV && status_i.div_needed && cnt_q == CNT_LAST) |=>
      state_q == ibe_pkg::ST_FIX)
    else $error("remainder sequence did not end after its last bit");
`endif

endmodule

[design/ibe_datapath.sv]
module ibe_datapath #(
  parameter int MAX_WIDTH  = ibe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ibe_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_PAD    = ibe_pkg::DEF_MAX_PAD,
  parameter int CHANNELS   = ibe_pkg::DEF_CHANNELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  input  logic [ibe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ibe_pkg::CFG_W-1:0]    cfg_data_i,
  // input item fields
  input  logic [ibe_pkg::CRD_W-1:0]    s_col_i,
  input  logic [ibe_pkg::CRD_W-1:0]    s_row_i,
  input  logic [ibe_pkg::PIX_W-1:0]    s_pixel_i,
  // controller link
  input  ibe_pkg::ctrl_cmd_t           cmd_i,
  output ibe_pkg::ctrl_status_t        status_o,
  // result side
  input  logic                         m_tready_i,
  output logic                         m_tvalid_o,
  output logic [ibe_pkg::PIX_W-1:0]    m_pixel_o,
  output logic                         m_status_o
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STORE_W = 8 * CHANNELS;

  localparam int unsigned CFG_W = ibe_pkg::CFG_W;
  localparam int unsigned SGN_W = ibe_pkg::SGN_W;
  localparam int unsigned MAG_W = ibe_pkg::MAG_W;
  localparam int unsigned AXES  = ibe_pkg::NUM_AXES;

  typedef struct packed {
    logic [MAG_W-1:0] mag;   // value to reduce, or the final index
    logic             neg;   // result is size minus remainder
    logic             wrap;  // remainder needed
  } axis_prep_t;

  // Clamp a size register into 1..max
  function automatic logic [CFG_W-1:0] sat_dim(logic [CFG_W-1:0] v, int maxv);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > 32'(maxv)) begin
      res = CFG_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Clamp a pad register to MAX_PAD
  function automatic logic [CFG_W-1:0] sat_pad(logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] res;
    if (32'(v) > 32'(MAX_PAD)) begin
      res = CFG_W'(MAX_PAD);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Per-axis mapping of an offset x onto [0, n)
  function automatic axis_prep_t prep_axis(logic signed [SGN_W-1:0] x,
                                           logic [CFG_W-1:0] n, logic mirror);
    axis_prep_t res;
    logic signed [SGN_W-1:0] nn;
    logic signed [SGN_W-1:0] d;
    logic signed [SGN_W-1:0] t;
    nn  = $signed({3'b000, n});
    d   = x - nn;
    t   = nn + nn - $signed(SGN_W'(2)) - x;   // 2n - x - 2
    res = '0;
    if (!x[SGN_W-1] && d[SGN_W-1]) begin
      res.mag = MAG_W'(x);
    end else if (!mirror) begin
      res.mag = x[SGN_W-1] ? '0 : MAG_W'(nn - $signed(SGN_W'(1)));
    end else if (x[SGN_W-1]) begin
      res.mag  = MAG_W'(-x);
      res.wrap = 1'b1;
    end else if (!t[SGN_W-1]) begin
      res.mag = MAG_W'(t);
    end else begin
      // truncating remainder of a negative value, then folded up by n
      res.mag  = MAG_W'(-t);
      res.neg  = 1'b1;
      res.wrap = 1'b1;
    end
    return res;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0]    width_q, height_q;
  logic [CFG_W-1:0]    pad_left_q, pad_right_q, pad_top_q, pad_bottom_q;
  ibe_pkg::edge_mode_e edge_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ibe_pkg::DIM_RESET;
      height_q     <= ibe_pkg::DIM_RESET;
      pad_left_q   <= '0;
      pad_right_q  <= '0;
      pad_top_q    <= '0;
      pad_bottom_q <= '0;
      edge_mode_q  <= ibe_pkg::EDGE_REPLICATE;
    end else if (cfg_valid_i) begin
      unique case (ibe_pkg::cfg_reg_e'(cfg_index_i))
        ibe_pkg::REG_SRC_WIDTH:  width_q      <= cfg_data_i;
        ibe_pkg::REG_SRC_HEIGHT: height_q     <= cfg_data_i;
        ibe_pkg::REG_PAD_LEFT:   pad_left_q   <= cfg_data_i;
        ibe_pkg::REG_PAD_RIGHT:  pad_right_q  <= cfg_data_i;
        ibe_pkg::REG_PAD_TOP:    pad_top_q    <= cfg_data_i;
        ibe_pkg::REG_PAD_BOTTOM: pad_bottom_q <= cfg_data_i;
        ibe_pkg::REG_EDGE_MODE:  edge_mode_q  <= ibe_pkg::edge_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Effective sizes per axis
  logic [AXES-1:0][CFG_W-1:0] dim, pad_lead, pad_trail;

  always_comb begin
    dim[0]       = sat_dim(width_q, MAX_WIDTH);
    dim[1]       = sat_dim(height_q, MAX_HEIGHT);
    pad_lead[0]  = sat_pad(pad_left_q);
    pad_lead[1]  = sat_pad(pad_top_q);
    pad_trail[0] = sat_pad(pad_right_q);
    pad_trail[1] = sat_pad(pad_bottom_q);
  end

  // Source store
  logic [STORE_W-1:0] mem_q [DEPTH];
  logic [STORE_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               wr_in_range;
  logic [AXES-1:0][CFG_W-1:0] idx_q, idx_d;

  assign wr_in_range = (s_col_i < {1'b0, dim[0]}) && (s_row_i < {1'b0, dim[1]});
  assign wr_addr = ADDR_W'(32'(s_row_i) * 32'(MAX_WIDTH) + 32'(s_col_i));
  assign rd_addr = ADDR_W'(32'(idx_q[1]) * 32'(MAX_WIDTH) + 32'(idx_q[0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_in_range) begin
      mem_q[wr_addr] <= s_pixel_i[STORE_W-1:0];
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Fetch coordinate, bounds check and offsets
  logic [AXES-1:0][ibe_pkg::CRD_W-1:0] crd_q;
  logic [AXES-1:0][SGN_W-1:0]          x_q;
  logic                                outside_q;
  logic [AXES-1:0]                     out_axis;
  logic [AXES-1:0][CFG_W+1:0]          span;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      span[a] = (CFG_W+2)'(pad_lead[a]) + (CFG_W+2)'(dim[a]) + (CFG_W+2)'(pad_trail[a]);
      out_axis[a] = ((CFG_W+2)'(crd_q[a]) >= span[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      crd_q[0] <= s_col_i;
      crd_q[1] <= s_row_i;
    end
    if (cmd_i.check) begin
      outside_q <= |out_axis;
      for (int a = 0; a < AXES; a++) begin
        x_q[a] <= $signed({2'b00, crd_q[a]}) - $signed({3'b000, pad_lead[a]});
      end
    end
  end

  // Mapping setup, remainder steps and final index
  logic [AXES-1:0][MAG_W-1:0] mag_q;
  logic [AXES-1:0][CFG_W-1:0] rem_q;
  logic [AXES-1:0]            neg_q, wrap_q;
  axis_prep_t [AXES-1:0]      prep;
  logic [AXES-1:0][CFG_W:0]   rem_sh;
  logic [AXES-1:0][CFG_W-1:0] rem_val;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prep[a]   = prep_axis(x_q[a], dim[a], edge_mode_q == ibe_pkg::EDGE_MIRROR);
      rem_sh[a] = {rem_q[a], mag_q[a][MAG_W-1]};
      rem_val[a] = wrap_q[a] ? rem_q[a] : CFG_W'(mag_q[a]);
      idx_d[a]  = (neg_q[a] && rem_val[a] != '0) ? dim[a] - rem_val[a] : rem_val[a];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      if (cmd_i.prep) begin
        mag_q[a]  <= prep[a].mag;
        neg_q[a]  <= prep[a].neg;
        wrap_q[a] <= prep[a].wrap;
        rem_q[a]  <= '0;
      end else if (cmd_i.div_step && wrap_q[a]) begin
        // restoring remainder, one dividend bit per step
        if (rem_sh[a] >= {1'b0, dim[a]}) begin
          rem_q[a] <= CFG_W'(rem_sh[a] - {1'b0, dim[a]});
        end else begin
          rem_q[a] <= CFG_W'(rem_sh[a]);
        end
        mag_q[a] <= {mag_q[a][MAG_W-2:0], 1'b0};
      end
      if (cmd_i.fix) begin
        idx_q[a] <= idx_d[a];
      end
    end
  end

  // Output register
  logic                      out_valid_q;
  logic [ibe_pkg::PIX_W-1:0] out_pixel_q;
  logic                      out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_q  <= outside_q ? '0 : ibe_pkg::PIX_W'(rd_data_q);
      out_status_q <= outside_q ? ibe_pkg::STATUS_OUTSIDE : ibe_pkg::STATUS_OK;
    end
  end

  assign m_tvalid_o          = out_valid_q;
  assign m_pixel_o           = out_pixel_q;
  assign m_status_o          = out_status_q;
  assign status_o.outside    = outside_q;
  assign status_o.div_needed = |wrap_q;
  assign status_o.out_free   = !out_valid_q || m_tready_i;

`ifndef SYNTH
  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten while occupied");

  // An outside fetch carries a zero pixel
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ibe_pkg::STATUS_OUTSIDE) |-> out_pixel_q == '0)
    else $error("outside fetch returned a nonzero pixel");

  // Results appear only through a controller load
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_load))
    else $error("result valid without an output load");
`endif

endmodule

[design/image_border_expand.sv]
// Border-expanding image server: stores a source image, answers fetches of the padded image.
// A fetch runs the check, then, unless it is outside the padded image, the mapping setup,
// the remainder steps only when the mirror wrap needs them (the bit-serial remainder unit
// takes one step per bit of a 10-bit magnitude), the index fix and the store read.
// Throughput: one load per cycle while idle; no item is taken until a fetch's result is loaded.
// Reset: asynchronous, active low; restores the registers, the store is not cleared.
module image_border_expand #(
  parameter int MAX_WIDTH  = ibe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ibe_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_PAD    = ibe_pkg::DEF_MAX_PAD,
  parameter int CHANNELS   = ibe_pkg::DEF_CHANNELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ibe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ibe_pkg::CFG_W-1:0]      cfg_data_i,
  // input stream
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [ibe_pkg::S_TDATA_W-1:0]  s_tdata_i,  // col[9:0], row[19:10], pixel[51:20], zero
  input  logic [ibe_pkg::S_TUSER_W-1:0]  s_tuser_i,  // op[0]
  // result stream
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [ibe_pkg::M_TDATA_W-1:0]  m_tdata_o,  // out_pixel[31:0]
  output logic [ibe_pkg::M_TUSER_W-1:0]  m_tuser_o   // status[0]
);

  ibe_pkg::ctrl_cmd_t    cmd;
  ibe_pkg::ctrl_status_t status;
  logic                  out_status;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  ibe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_op_i     (ibe_pkg::op_e'(s_tuser_i[0])),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ibe_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_PAD    (MAX_PAD),
    .CHANNELS   (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_col_i     (s_tdata_i[ibe_pkg::COL_LSB +: ibe_pkg::CRD_W]),
    .s_row_i     (s_tdata_i[ibe_pkg::ROW_LSB +: ibe_pkg::CRD_W]),
    .s_pixel_i   (s_tdata_i[ibe_pkg::PIX_LSB +: ibe_pkg::PIX_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_pixel_o   (m_tdata_o),
    .m_status_o  (out_status)
  );

  assign m_tuser_o = ibe_pkg::M_TUSER_W'(out_status);

endmodule

[dv/border_fetch_checker.sv]
// Watches the register, input and result channels of the border expander,
// keeps its own copy of the source image and registers, and compares every
// result transaction with the answer predicted for the oldest open fetch.
module border_fetch_checker
  import ibe_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_PAD    = DEF_MAX_PAD,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,  // col[9:0], row[19:10], pixel[51:20], zero
  input  logic [S_TUSER_W-1:0] s_tuser_i,  // op[0]
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,  // out_pixel[31:0]
  input  logic [M_TUSER_W-1:0] m_tuser_i,  // status[0]
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMAGE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [PIX_W-1:0] CHAN_MASK = PIX_W'((64'd1 << (8 * CHANNELS)) - 64'd1);
  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    status_e          status;
  } fetch_answer_t;

  fetch_answer_t    open_fetches_q[$];
  logic [PIX_W-1:0] image_mem [0:IMAGE_DEPTH-1];

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] pad_l_q, pad_r_q, pad_t_q, pad_b_q;
  edge_mode_e       mode_q;

  int errors;
  int checked;

  initial begin
    errors  = 0;
    checked = 0;
  end

  // Size registers: zero acts as one, anything above the maximum saturates
  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned clamp_pad(logic [CFG_W-1:0] v);
    return (v > MAX_PAD) ? MAX_PAD : v;
  endfunction

  // Fold an expanded coordinate back onto [0, n) for one axis
  function automatic int unsigned fold_axis(int unsigned e, int unsigned lead, int unsigned n);
    int x;
    int nn;
    int v;
    x  = int'(e) - int'(lead);
    nn = int'(n);
    if (x >= 0 && x < nn) return x;
    if (mode_q == EDGE_REPLICATE) return (x < 0) ? 0 : n - 1;
    if (x < 0) begin
      v = (-x) % nn;
    end else begin
      // reflection about the last index, then truncating remainder
      v = (2 * nn - x - 2) % nn;
      if (v < 0) v += nn;
    end
    return v;
  endfunction

  function automatic fetch_answer_t predict_fetch(int unsigned col, int unsigned row);
    fetch_answer_t ans;
    int unsigned   w, h, pl, pr, pt, pb, sc, sr;
    w  = clamp_size(width_q, MAX_WIDTH);
    h  = clamp_size(height_q, MAX_HEIGHT);
    pl = clamp_pad(pad_l_q);
    pr = clamp_pad(pad_r_q);
    pt = clamp_pad(pad_t_q);
    pb = clamp_pad(pad_b_q);
    if (col >= pl + w + pr || row >= pt + h + pb) begin
      ans.pixel  = '0;
      ans.status = STATUS_OUTSIDE;
    end else begin
      sc         = fold_axis(col, pl, w);
      sr         = fold_axis(row, pt, h);
      ans.pixel  = image_mem[(sr * MAX_WIDTH + sc) % IMAGE_DEPTH];
      ans.status = STATUS_OK;
    end
    return ans;
  endfunction

  // All three channels are sampled at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    fetch_answer_t        want;
    logic [CRD_W-1:0]     col, row;
    int unsigned          w, h;
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      pad_l_q  <= '0;
      pad_r_q  <= '0;
      pad_t_q  <= '0;
      pad_b_q  <= '0;
      mode_q   <= EDGE_REPLICATE;
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SRC_WIDTH:  width_q  <= cfg_data_i;
          REG_SRC_HEIGHT: height_q <= cfg_data_i;
          REG_PAD_LEFT:   pad_l_q  <= cfg_data_i;
          REG_PAD_RIGHT:  pad_r_q  <= cfg_data_i;
          REG_PAD_TOP:    pad_t_q  <= cfg_data_i;
          REG_PAD_BOTTOM: pad_b_q  <= cfg_data_i;
          REG_EDGE_MODE:  mode_q   <= edge_mode_e'(cfg_data_i[0]);
          default: ;
        endcase
      end

      // result transaction against the oldest open fetch
      if (m_tvalid_i && m_tready_i) begin
        if (open_fetches_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: result with no open fetch: expected none, got pixel %h status %0d",
                     $time, m_tdata_i, m_tuser_i[0]);
        end else begin
          want = open_fetches_q.pop_front();
          checked++;
          if (m_tdata_i !== want.pixel) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: out_pixel mismatch: expected %h, actual %h",
                       $time, want.pixel, m_tdata_i);
          end
          if (m_tuser_i[0] !== want.status) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: status mismatch: expected %0d, actual %0d",
                       $time, want.status, m_tuser_i[0]);
          end
        end
      end

      // input transaction: loads update the image, fetches open an answer
      if (s_tvalid_i && s_tready_i) begin
        col = s_tdata_i[COL_LSB +: CRD_W];
        row = s_tdata_i[ROW_LSB +: CRD_W];
        if (s_tuser_i[0] == OP_LOAD) begin
          w = clamp_size(width_q, MAX_WIDTH);
          h = clamp_size(height_q, MAX_HEIGHT);
          if (col < w && row < h)
            image_mem[row * MAX_WIDTH + col] = s_tdata_i[PIX_LSB +: PIX_W] & CHAN_MASK;
        end else begin
          open_fetches_q.push_back(predict_fetch(col, row));
        end
      end
    end
    errors_o  <= errors;
    pending_o <= open_fetches_q.size();
    checked_o <= checked;
  end

endmodule

[dv/testbench.sv]
// Stimulus and verdict for the border expander; checking lives in border_fetch_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ibe_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int          ITEM_TARGET  = 2000;
  localparam int          MIX_ITEMS    = 120;
  localparam int          DRAIN_CYCLES = 24;  // longest fetch latency plus margin
  localparam int          HOLD_AFTER   = 150; // results seen before the long hold-off
  localparam int          HOLD_CYCLES  = 600;
  localparam int          COORD_MAX    = (1 << CRD_W) - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_tvalid_i;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i;  // col[9:0], row[19:10], pixel[51:20], zero
  logic [S_TUSER_W-1:0] s_tuser_i;  // op[0]
  logic                 m_tvalid_o;
  logic                 m_tready_i;
  logic [M_TDATA_W-1:0] m_tdata_o;  // out_pixel[31:0]
  logic [M_TUSER_W-1:0] m_tuser_o;  // status[0]

  int errors, pending, checked;

  image_border_expand dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  border_fetch_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_i   (m_tdata_o),
    .m_tuser_i   (m_tuser_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Effective geometry of the current setting, used to shape coordinates
  int unsigned cur_w, cur_h, cur_pl, cur_pr, cur_pt, cur_pb;
  bit          loaded_map [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  int          burst_left;
  int          items_counted, loads, dropped, fetches, outside, settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: windows of different stall styles, one long hold-off
  initial begin : receiver
    int mode, span, seen;
    bit held;
    seen = 0;
    held = 1'b0;
    m_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk_i);
        if (m_tvalid_o && m_tready_i) seen++;
        if (!held && seen >= HOLD_AFTER) begin
          held = 1'b1;
          m_tready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       m_tready_i <= 1'b1;
            1:       m_tready_i <= 1'($urandom_range(0, 1));
            2:       m_tready_i <= ($urandom_range(0, 3) == 0);
            default: m_tready_i <= ~m_tready_i;
          endcase
        end
      end
    end
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned eff_pad(logic [CFG_W-1:0] v);
    return (v > DEF_MAX_PAD) ? DEF_MAX_PAD : v;
  endfunction

  // Oversized register values, all saturating to the maximum
  function automatic logic [CFG_W-1:0] big_dim();
    case ($urandom_range(0, 2))
      0:       return CFG_W'(256);
      1:       return CFG_W'($urandom_range(257, 510));
      default: return CFG_W'(511);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_pad();
    case ($urandom_range(0, 9))
      0:       return big_dim();
      1:       return '0;
      default: return CFG_W'($urandom_range(1, 20));
    endcase
  endfunction

  // Coordinate on one axis, weighted toward the pad and image borders
  function automatic logic [CRD_W-1:0] pick_coord(int unsigned lead, int unsigned n,
                                                  int unsigned trail);
    int unsigned span;
    span = lead + n + trail;
    case ($urandom_range(0, 9))
      0: return CRD_W'($urandom_range(0, COORD_MAX));
      1: return CRD_W'(span);
      2, 3: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return CRD_W'(lead);
          2:       return CRD_W'(lead + n - 1);
          3:       return CRD_W'(span - 1);
          default: return CRD_W'((lead > 0) ? lead - 1 : lead + n);
        endcase
      end
      default: return CRD_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  // Offer one input transaction; the valid stays up unless a gap follows
  task automatic offer(op_e op, logic [CRD_W-1:0] col, logic [CRD_W-1:0] row,
                       logic [PIX_W-1:0] pix);
    int gap;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {{(S_TDATA_W - PIX_W - 2 * CRD_W){1'b0}}, pix, row, col};
    do @(posedge clk_i); while (!s_tready_o);
    if (op == OP_LOAD) begin
      if (col < cur_w && row < cur_h) begin
        loads++;
        items_counted++;
        loaded_map[row * DEF_MAX_WIDTH + col] = 1'b1;
      end else begin
        dropped++;
      end
    end else begin
      fetches++;
      items_counted++;
      if (col >= cur_pl + cur_w + cur_pr || row >= cur_pt + cur_h + cur_pb) outside++;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Wait until every fetch has been answered and the block has gone quiet
  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                               logic [CFG_W-1:0] pl, logic [CFG_W-1:0] pr,
                               logic [CFG_W-1:0] pt, logic [CFG_W-1:0] pb, edge_mode_e m);
    drain();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_PAD_LEFT, pl);
    write_reg(REG_PAD_RIGHT, pr);
    write_reg(REG_PAD_TOP, pt);
    write_reg(REG_PAD_BOTTOM, pb);
    // upper bits of the mode write are don't-care
    write_reg(REG_EDGE_MODE, {8'($urandom_range(0, 255)), m});
    cfg_valid_i <= 1'b0;
    cur_w  = eff_size(w, DEF_MAX_WIDTH);
    cur_h  = eff_size(h, DEF_MAX_HEIGHT);
    cur_pl = eff_pad(pl);
    cur_pr = eff_pad(pr);
    cur_pt = eff_pad(pt);
    cur_pb = eff_pad(pb);
    settings++;
  endtask

  // Small image with pads wider than it, so the mirror wrap is exercised
  task automatic run_directed();
    logic [PIX_W-1:0] pixels [6];
    logic [CRD_W-1:0] fcol [6];
    logic [CRD_W-1:0] frow [6];
    pixels = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
               PIX_W'($urandom), PIX_W'($urandom)};
    fcol   = '{10'd0, 10'd7, 10'd18, 10'd19, 10'd0, 10'd1023};
    frow   = '{10'd0, 10'd5, 10'd10, 10'd0, 10'd11, 10'd1023};
    apply_setting(9'd3, 9'd2, 9'd7, 9'd9, 9'd5, 9'd4, EDGE_MIRROR);
    for (int i = 0; i < 6; i++) offer(OP_LOAD, CRD_W'(i % 3), CRD_W'(i / 3), pixels[i]);
    // loads outside the source are dropped
    offer(OP_LOAD, 10'd1023, 10'd0, 32'hFFFF_FFFF);
    offer(OP_LOAD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    offer(OP_LOAD, 10'd3, 10'd1, 32'h1234_5678);
    for (int i = 0; i < 6; i++) offer(OP_FETCH, fcol[i], frow[i], 32'hFFFF_FFFF);
    apply_setting(9'd3, 9'd2, 9'd7, 9'd9, 9'd5, 9'd4, EDGE_REPLICATE);
    for (int i = 0; i < 6; i++) offer(OP_FETCH, fcol[i], frow[i], '0);
  endtask

  task automatic random_setting();
    logic [CFG_W-1:0] w, h;
    int shape;
    shape = $urandom_range(0, 5);
    w = CFG_W'($urandom_range(0, 12));
    h = CFG_W'($urandom_range(0, 12));
    if (shape == 0) begin
      w = big_dim();
      h = CFG_W'($urandom_range(0, 2));
    end else if (shape == 1) begin
      h = big_dim();
      w = CFG_W'($urandom_range(0, 2));
    end
    apply_setting(w, h, rand_pad(), rand_pad(), rand_pad(), rand_pad(),
                  edge_mode_e'($urandom_range(0, 1)));
  endtask

  // Fill the source area; entries kept from earlier settings are partly left alone
  task automatic load_image();
    for (int r = 0; r < cur_h; r++) begin
      for (int c = 0; c < cur_w; c++) begin
        if (!loaded_map[r * DEF_MAX_WIDTH + c] || $urandom_range(0, 1))
          offer(OP_LOAD, CRD_W'(c), CRD_W'(r), PIX_W'($urandom));
        if ($urandom_range(0, 15) == 0)
          offer(OP_LOAD, CRD_W'($urandom_range(cur_w, COORD_MAX)), CRD_W'(r), PIX_W'($urandom));
      end
    end
  endtask

  task automatic mixed_traffic(int n);
    int sel;
    logic [CRD_W-1:0] c, r;
    repeat (n) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        c = pick_coord(cur_pl, cur_w, cur_pr);
        r = pick_coord(cur_pt, cur_h, cur_pb);
        offer(OP_FETCH, c, r, PIX_W'($urandom));
      end else if (sel < 17) begin
        c = CRD_W'($urandom_range(0, cur_w - 1));
        r = CRD_W'($urandom_range(0, cur_h - 1));
        offer(OP_LOAD, c, r, PIX_W'($urandom));
      end else begin
        if ($urandom_range(0, 1)) begin
          c = CRD_W'($urandom_range(cur_w, COORD_MAX));
          r = CRD_W'($urandom_range(0, COORD_MAX));
        end else begin
          c = CRD_W'($urandom_range(0, COORD_MAX));
          r = CRD_W'($urandom_range(cur_h, COORD_MAX));
        end
        offer(OP_LOAD, c, r, PIX_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_SRC_WIDTH;
    cfg_data_i  <= '0;
    s_tvalid_i  <= 1'b0;
    s_tuser_i   <= OP_LOAD;
    s_tdata_i   <= '0;
    burst_left    = 1;
    items_counted = 0;
    loads         = 0;
    dropped       = 0;
    fetches       = 0;
    outside       = 0;
    settings      = 0;
    cur_w  = eff_size(DIM_RESET, DEF_MAX_WIDTH);
    cur_h  = eff_size(DIM_RESET, DEF_MAX_HEIGHT);
    cur_pl = 0;
    cur_pr = 0;
    cur_pt = 0;
    cur_pb = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    while (items_counted < ITEM_TARGET) begin
      random_setting();
      load_image();
      mixed_traffic(MIX_ITEMS);
    end
    drain();

    $display("Sent %0d loads (%0d more dropped outside the source) and %0d fetches (%0d off the padded image) over %0d register settings.",
             loads, dropped, fetches, outside, settings);
    $display("Compared %0d fetch results, with one %0d-cycle hold-off on the result side.",
             checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
